// ----- hw/rtl/sfb_pkg.sv -----
// Shared types, codes and servo tables for the servo frame builder.
// No dependencies; used by sfb_pulse_unit, sfb_crc_unit and the top level.
package sfb_pkg;

    localparam int SLOT_COUNT_DEF  = 20;
    localparam int FRAME_WORDS_DEF = 21;

    localparam int LOGICAL_SERVOS = 18;
    localparam logic [15:0] PULSE_CENTER = 16'd1500;
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_MOVE   = 2'd0;
    localparam logic [1:0] MODE_ALL    = 2'd1;
    localparam logic [1:0] MODE_COMMIT = 2'd2;

    typedef struct packed {
        logic        valid;
        logic [4:0]  slot;
        logic [31:0] word;
    } t_place;

    // physical slot for each logical servo
    function automatic logic [4:0] slot_of(input logic [4:0] idx);
        logic [4:0] s;
        unique case (idx)
            5'd0:    s = 5'd3;
            5'd1:    s = 5'd2;
            5'd2:    s = 5'd1;
            5'd3:    s = 5'd0;
            5'd4:    s = 5'd7;
            5'd5:    s = 5'd6;
            5'd6:    s = 5'd5;
            5'd7:    s = 5'd4;
            5'd8:    s = 5'd11;
            5'd9:    s = 5'd14;
            5'd10:   s = 5'd15;
            5'd11:   s = 5'd8;
            5'd12:   s = 5'd19;
            5'd13:   s = 5'd12;
            5'd14:   s = 5'd13;
            5'd15:   s = 5'd16;
            5'd16:   s = 5'd17;
            5'd17:   s = 5'd18;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // servos on the mirrored side run with inverted direction
    function automatic logic negate_of(input logic [4:0] idx);
        return (idx >= 5'd9) && (idx <= 5'd17);
    endfunction

    // calibration trim in pulse units, two's complement
    function automatic logic [15:0] trim_of(input logic [4:0] idx);
        logic signed [15:0] t;
        unique case (idx)
            5'd0:    t = 16'sd20;
            5'd1:    t = 16'sd30;
            5'd2:    t = 16'sd20;
            5'd3:    t = 16'sd60;
            5'd4:    t = 16'sd20;
            5'd5:    t = -16'sd40;
            5'd6:    t = -16'sd50;
            5'd7:    t = 16'sd50;
            5'd8:    t = 16'sd0;
            5'd9:    t = 16'sd30;
            5'd10:   t = -16'sd170;
            5'd11:   t = -16'sd20;
            5'd12:   t = 16'sd20;
            5'd13:   t = -16'sd120;
            5'd14:   t = -16'sd40;
            5'd15:   t = 16'sd20;
            5'd16:   t = -16'sd20;
            5'd17:   t = -16'sd20;
            default: t = 16'sd0;
        endcase
        return t;
    endfunction

endpackage

// ----- hw/rtl/sfb_pulse_unit.sv -----
// Shared pulse unit: builds one command word and its slot for a logical servo.
// Depends on sfb_pkg (tables, t_place).
module sfb_pulse_unit (
    input  logic [4:0]         i_idx,
    input  logic [15:0]        i_position,
    input  logic [15:0]        i_move_time,
    output sfb_pkg::t_place    o_place
);

    logic [15:0] pos_dir;
    logic [15:0] pulse;

    always_comb begin
        pos_dir = sfb_pkg::negate_of(i_idx) ? (16'd0 - i_position) : i_position;
        pulse   = sfb_pkg::PULSE_CENTER + pos_dir + sfb_pkg::trim_of(i_idx);
        o_place.valid = (i_idx < 5'(sfb_pkg::LOGICAL_SERVOS));
        o_place.slot  = sfb_pkg::slot_of(i_idx);
        o_place.word  = {i_move_time, pulse};
    end

endmodule

// ----- hw/rtl/sfb_crc_unit.sv -----
// CRC-32/MPEG-2 byte step: folds one byte, MSB first, into the running CRC.
// Depends on sfb_pkg (polynomial).
module sfb_crc_unit (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    logic [31:0] c;

    always_comb begin
        c = i_crc ^ {i_byte, 24'd0};
        for (int b = 0; b < 8; b++) begin
            c = c[31] ? ((c << 1) ^ sfb_pkg::CRC_POLY) : (c << 1);
        end
        o_crc = c;
    end

endmodule

// ----- hw/rtl/servo_frame_builder_crc32_core.sv -----
// Servo frame builder: command store, move/commit sequencer, frame output.
// Depends on sfb_pkg, sfb_pulse_unit and sfb_crc_unit.
//
// Usage:
//   Slave channel (i_s_*) takes one item per transfer. tuser carries the mode:
//   move one servo, move all servos, or commit the frame.
//   Master channel (o_m_*) carries frame words; tlast marks the CRC word.
// Sequence:
//   Move one: the servo's word is written to the command store in the move state; no output.
//   Move all: one servo per cycle through the shared pulse unit.
//   Commit: FRAME_WORDS-1 data words, each folded into the CRC one byte per
//   cycle, then presented; the CRC word follows the last data word.
//   One item is in work at a time; o_s_tready is high only when idle.
// Reset: clears the command store and the sequencer; no output is pending.
// Stall: a held output word stays on o_m_tdata and the sequencer waits.
module servo_frame_builder_crc32_core #(
    parameter int SLOT_COUNT  = sfb_pkg::SLOT_COUNT_DEF,
    parameter int FRAME_WORDS = sfb_pkg::FRAME_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // servo_index[4:0], position[20:5], move_time[36:21]
    input  logic [1:0]  i_s_tuser,   // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // frame_word[31:0]
    output logic        o_m_tlast
);

    localparam int SIDX_W = $clog2(SLOT_COUNT);
    localparam int WORD_W = $clog2(FRAME_WORDS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOVE = 3'd1;
    localparam logic [2:0] ST_FOLD = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;

    logic [2:0]        r_state, n_state;
    logic [4:0]        r_idx, n_idx;
    logic              r_all, n_all;
    logic [15:0]       r_pos, n_pos;
    logic [15:0]       r_time, n_time;
    logic [WORD_W-1:0] r_word, n_word;
    logic [1:0]        r_byte, n_byte;
    logic [31:0]       r_crc, n_crc;
    logic [31:0]       r_out, n_out;
    logic              r_last, n_last;
    logic [31:0]       r_store [SLOT_COUNT];

    sfb_pkg::t_place   place;
    logic [31:0]       cur_word;
    logic [7:0]        cur_byte;
    logic [31:0]       crc_next;
    logic              store_we;
    logic [SIDX_W-1:0] store_widx;
    logic              s_xfer;
    logic              m_xfer;

    sfb_pulse_unit u_pulse (
        .i_idx       (r_idx),
        .i_position  (r_pos),
        .i_move_time (r_time),
        .o_place     (place)
    );

    sfb_crc_unit u_crc (
        .i_crc  (r_crc),
        .i_byte (cur_byte),
        .o_crc  (crc_next)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_EMIT);
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_last;
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign m_xfer     = o_m_tvalid && i_m_tready;

    always_comb begin
        cur_word = (32'(r_word) < 32'(SLOT_COUNT)) ? r_store[SIDX_W'(r_word)] : 32'd0;
        unique case (r_byte)
            2'd0:    cur_byte = cur_word[31:24];
            2'd1:    cur_byte = cur_word[23:16];
            2'd2:    cur_byte = cur_word[15:8];
            default: cur_byte = cur_word[7:0];
        endcase
        store_we   = (r_state == ST_MOVE) && place.valid &&
                     (32'(place.slot) < 32'(SLOT_COUNT));
        store_widx = SIDX_W'(place.slot);
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_all   = r_all;
        n_pos   = r_pos;
        n_time  = r_time;
        n_word  = r_word;
        n_byte  = r_byte;
        n_crc   = r_crc;
        n_out   = r_out;
        n_last  = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_pos  = i_s_tdata[20:5];
                    n_time = i_s_tdata[36:21];
                    n_word = '0;
                    n_byte = 2'd0;
                    n_crc  = sfb_pkg::CRC_INIT;
                    n_last = 1'b0;
                    priority if (i_s_tuser == sfb_pkg::MODE_MOVE) begin
                        n_idx   = i_s_tdata[4:0];
                        n_all   = 1'b0;
                        n_state = ST_MOVE;
                    end else if (i_s_tuser == sfb_pkg::MODE_ALL) begin
                        n_idx   = 5'd0;
                        n_all   = 1'b1;
                        n_state = ST_MOVE;
                    end else if (i_s_tuser == sfb_pkg::MODE_COMMIT) begin
                        n_state = ST_FOLD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MOVE: begin
                if (!r_all || r_idx == 5'(sfb_pkg::LOGICAL_SERVOS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            ST_FOLD: begin
                n_crc  = crc_next;
                n_byte = r_byte + 2'd1;
                if (r_byte == 2'd3) begin
                    n_out   = cur_word;
                    n_last  = 1'b0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_xfer) begin
                    if (r_last) begin
                        n_last  = 1'b0;
                        n_state = ST_IDLE;
                    end else if (r_word == WORD_W'(FRAME_WORDS - 2)) begin
                        n_out  = r_crc;
                        n_last = 1'b1;
                    end else begin
                        n_word  = r_word + WORD_W'(1);
                        n_byte  = 2'd0;
                        n_state = ST_FOLD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
            r_all   <= 1'b0;
            r_byte  <= 2'd0;
            r_word  <= '0;
            r_crc   <= sfb_pkg::CRC_INIT;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_all   <= n_all;
            r_byte  <= n_byte;
            r_word  <= n_word;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_time <= n_time;
        r_out  <= n_out;
    end

    // command store, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_store[i] <= 32'd0;
            end
        end else if (store_we) begin
            r_store[store_widx] <= place.word;
        end
    end

endmodule

// ----- test/servo_frame_builder_crc32_core_tb.sv -----
// Self-checking testbench for servo_frame_builder_crc32_core: directed table, then random
// phases with idling and a long output hold. Depends on sfb_pkg and the core RTL only.
`timescale 1ns / 1ps

module servo_frame_builder_crc32_core_tb;

    localparam int SLOTS        = sfb_pkg::SLOT_COUNT_DEF;
    localparam int FRAME        = sfb_pkg::FRAME_WORDS_DEF;
    localparam int LIMIT        = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int PHASE_ITEMS  = 80;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // logical servo -> physical slot, direction flip, trim
    localparam logic [4:0] SERVO_SLOT [18] = '{
        5'd3, 5'd2, 5'd1, 5'd0, 5'd7, 5'd6, 5'd5, 5'd4, 5'd11,
        5'd14, 5'd15, 5'd8, 5'd19, 5'd12, 5'd13, 5'd16, 5'd17, 5'd18
    };
    localparam logic SERVO_FLIP [18] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };
    localparam logic [15:0] SERVO_TRIM [18] = '{
        16'd20, 16'd30, 16'd20, 16'd60, 16'd20, -16'd40, -16'd50, 16'd50, 16'd0,
        16'd30, -16'd170, -16'd20, 16'd20, -16'd120, -16'd40, 16'd20, -16'd20, -16'd20
    };

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  idx;
        logic [15:0] pos;
        logic [15:0] mtime;
    } t_item;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_frame_word;

    // directed row: item, plus an optional hand-computed frame word at a given position
    typedef struct packed {
        t_item       item;
        logic        chk;
        logic [4:0]  chk_at;
        logic [31:0] chk_word;
    } t_row;

    localparam int DIR_ROWS = 23;
    localparam t_row DIRECTED [DIR_ROWS] = '{
        '{'{sfb_pkg::MODE_COMMIT, 5'd0,  16'h0000, 16'h0000}, 1'b1, 5'd0,  32'h0000_0000},
        '{'{sfb_pkg::MODE_MOVE,   5'd3,  16'h0000, 16'hFFFF}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_MOVE,   5'd0,  16'h7FFF, 16'h0000}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_MOVE,   5'd9,  16'h8000, 16'h8000}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_MOVE,   5'd10, 16'h7FFF, 16'h1234}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_COMMIT, 5'd0,  16'h0000, 16'h0000}, 1'b1, 5'd0,  32'hFFFF_0618},
        '{'{sfb_pkg::MODE_COMMIT, 5'd31, 16'hFFFF, 16'hFFFF}, 1'b1, 5'd3,  32'h0000_85EF},
        '{'{sfb_pkg::MODE_COMMIT, 5'd0,  16'h0000, 16'h0000}, 1'b1, 5'd14, 32'h8000_85FA},
        '{'{sfb_pkg::MODE_COMMIT, 5'd0,  16'h0000, 16'h0000}, 1'b1, 5'd15, 32'h1234_8533},
        // pulse goes below zero and wraps inside the low half
        '{'{sfb_pkg::MODE_MOVE,   5'd3,  16'hF9E7, 16'h0000}, 1'b0, 5'd0,  32'h0},
        // out-of-range servo numbers write nothing
        '{'{sfb_pkg::MODE_MOVE,   5'd18, 16'h1111, 16'h2222}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_MOVE,   5'd31, 16'hFFFF, 16'hFFFF}, 1'b0, 5'd0,  32'h0},
        '{'{MODE_SPARE,           5'd3,  16'hFFFF, 16'hFFFF}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_COMMIT, 5'd0,  16'h0000, 16'h0000}, 1'b1, 5'd0,  32'h0000_FFFF},
        '{'{sfb_pkg::MODE_ALL,    5'd0,  16'h0000, 16'hABCD}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_COMMIT, 5'd0,  16'h0000, 16'h0000}, 1'b1, 5'd0,  32'hABCD_0618},
        '{'{sfb_pkg::MODE_MOVE,   5'd3,  16'h8000, 16'h5555}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_COMMIT, 5'd0,  16'h0000, 16'h0000}, 1'b1, 5'd0,  32'h5555_8618},
        '{'{sfb_pkg::MODE_ALL,    5'd31, 16'hFFFF, 16'hFFFF}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_COMMIT, 5'd0,  16'h0000, 16'h0000}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_MOVE,   5'd12, 16'h7FFF, 16'h0000}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_MOVE,   5'd17, 16'h8000, 16'hFFFF}, 1'b0, 5'd0,  32'h0},
        '{'{sfb_pkg::MODE_COMMIT, 5'd0,  16'h0000, 16'h0000}, 1'b0, 5'd0,  32'h0}
    };

    localparam int GAP_PCT   [4] = '{0, 84, 0, 22};
    localparam int STALL_PCT [4] = '{0, 0, 84, 22};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // servo_index[4:0], position[20:5], move_time[36:21]
    logic [1:0]  i_s_tuser;   // mode[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // frame_word[31:0]
    logic        o_m_tlast;

    servo_frame_builder_crc32_core #(
        .SLOT_COUNT (SLOTS),
        .FRAME_WORDS(FRAME)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    // predictor state
    logic [31:0]  cmd_store [SLOTS];
    logic [31:0]  crc_acc;
    t_frame_word  frame_q [$];

    int err_cnt        = 0;
    int cyc_cnt        = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    bit hold_go        = 1'b0;
    bit hold_done      = 1'b0;
    int hold_left      = 0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int b = 0; b < 32; b++)
            c = c[31] ? ((c << 1) ^ sfb_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic void place_servo(input logic [4:0] idx, input logic [15:0] pos,
                                        input logic [15:0] mtime);
        logic [15:0] p;
        logic [15:0] pulse;
        logic [4:0]  slot;
        if (idx < sfb_pkg::LOGICAL_SERVOS) begin
            p     = SERVO_FLIP[idx] ? (16'd0 - pos) : pos;
            pulse = sfb_pkg::PULSE_CENTER + p + SERVO_TRIM[idx];
            slot  = SERVO_SLOT[idx];
            if (slot < SLOTS)
                cmd_store[slot] = {mtime, pulse};
        end
    endfunction

    // update the store, or for a commit queue the frame words and the closing CRC
    function automatic void apply_item(input t_item it, input logic chk,
                                       input logic [4:0] chk_at, input logic [31:0] chk_word);
        t_frame_word fw;
        logic [31:0] w;
        case (it.mode)
            sfb_pkg::MODE_MOVE: place_servo(it.idx, it.pos, it.mtime);
            sfb_pkg::MODE_ALL: begin
                for (int s = 0; s < sfb_pkg::LOGICAL_SERVOS; s++)
                    place_servo(5'(s), it.pos, it.mtime);
            end
            sfb_pkg::MODE_COMMIT: begin
                crc_acc = sfb_pkg::CRC_INIT;
                for (int i = 0; i < FRAME - 1; i++) begin
                    w       = (i < SLOTS) ? cmd_store[i] : 32'd0;
                    crc_acc = crc_fold(crc_acc, w);
                    fw.word = (chk && chk_at == i) ? chk_word : w;
                    fw.last = 1'b0;
                    frame_q.push_back(fw);
                end
                fw.word = crc_acc;
                fw.last = 1'b1;
                frame_q.push_back(fw);
            end
            default: ;
        endcase
    endfunction

    task automatic push_item(input t_item it, input logic chk, input logic [4:0] chk_at,
                             input logic [31:0] chk_word);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.mode;
        i_s_tdata  <= {3'b000, it.mtime, it.pos, it.idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        apply_item(it, chk, chk_at, chk_word);
    endtask

    // drop tvalid first so the last item is not taken twice
    task automatic wait_frames_done;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (frame_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : frame_check
        t_frame_word exp_fw;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected frame word: expected none, got %h last %b",
                         $time, o_m_tdata, o_m_tlast);
                err_cnt++;
            end else begin
                exp_fw = frame_q.pop_front();
                if (o_m_tdata !== exp_fw.word) begin
                    $display("%0t: frame word mismatch: expected %h, got %h",
                             $time, exp_fw.word, o_m_tdata);
                    err_cnt++;
                end
                if (o_m_tlast !== exp_fw.last) begin
                    $display("%0t: tlast mismatch: expected %b, got %b",
                             $time, exp_fw.last, o_m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_item it;
        int    counted;
        int    r;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = sfb_pkg::MODE_MOVE;
        i_m_tready = 1'b0;
        for (int s = 0; s < SLOTS; s++)
            cmd_store[s] = 32'd0;
        crc_acc = sfb_pkg::CRC_INIT;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++)
            push_item(DIRECTED[k].item, DIRECTED[k].chk, DIRECTED[k].chk_at,
                      DIRECTED[k].chk_word);
        wait_frames_done();

        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct   = GAP_PCT[ph];
            recv_stall_pct = STALL_PCT[ph];
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (ph == 0 && counted == 30) begin
                    // long output hold: the first commit backs up, the second waits at the input
                    hold_go = 1'b1;
                    it = '{sfb_pkg::MODE_COMMIT, 5'($urandom), 16'($urandom), 16'($urandom)};
                    push_item(it, 1'b0, 5'd0, 32'd0);
                    push_item(it, 1'b0, 5'd0, 32'd0);
                    counted += 2;
                end
                r        = $urandom_range(99);
                it.pos   = 16'($urandom);
                it.mtime = 16'($urandom);
                case ($urandom_range(9))
                    0: it.pos = 16'h8000;
                    1: it.pos = 16'h7FFF;
                    2: it.mtime = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
                    default: ;
                endcase
                if (r < 50) begin
                    it.mode = sfb_pkg::MODE_MOVE;
                    it.idx  = 5'($urandom_range(sfb_pkg::LOGICAL_SERVOS - 1));
                    counted++;
                end else if (r < 55) begin
                    it.mode = sfb_pkg::MODE_MOVE;
                    it.idx  = 5'($urandom_range(31, sfb_pkg::LOGICAL_SERVOS));
                end else if (r < 65) begin
                    it.mode = sfb_pkg::MODE_ALL;
                    it.idx  = 5'($urandom);
                    counted++;
                end else if (r < 85) begin
                    it.mode = sfb_pkg::MODE_COMMIT;
                    it.idx  = 5'($urandom);
                    counted++;
                end else begin
                    it.mode = MODE_SPARE;
                    it.idx  = 5'($urandom);
                end
                push_item(it, 1'b0, 5'd0, 32'd0);
            end
            // sender pauses until the block has drained
            wait_frames_done();
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait_frames_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
